@@ sv/lpc_pkg.sv @@
// shared constants, tables and types for the lidar polar to cartesian block
package lpc_pkg;

	localparam int INDEX_BITS    = 12;
	localparam int CORDIC_STAGES = 16;

	localparam int SP_W       = 12;
	localparam int DEG_W      = 9;
	localparam int PPM_W      = 8;
	localparam int RANGE_W    = 16;
	localparam int RS_W       = RANGE_W + PPM_W;
	localparam int BLK_W      = 4;
	localparam int WIN_W      = DEG_W + BLK_W;
	localparam int CMP_W      = (INDEX_BITS > WIN_W) ? INDEX_BITS : WIN_W;
	localparam int PHASE_W    = 32;
	localparam int DIV_BITS   = INDEX_BITS + PHASE_W;
	localparam int REM_W      = SP_W;
	localparam int VEC_W      = 32;
	localparam int ATAN_LEN   = 24;
	localparam int SHIFT_W    = $clog2(ATAN_LEN);
	localparam int PIX_W      = 18;
	localparam int PROD_W     = VEC_W + RS_W + 1;
	localparam int FRAC_SHIFT = 38;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	// floor(sp/360) = ((sp >> 3) * 1457) >> 16 for every 12 bit sp
	localparam int BLK_PRE_SHIFT   = 3;
	localparam int BLK_RECIP       = 1457;
	localparam int BLK_RECIP_SHIFT = 16;
	localparam int BLK_PROD_W      = 20;

	localparam logic [PHASE_W-1:0] OFFSET_PHASE = 32'd1080577477;
	localparam logic [PHASE_W-1:0] EIGHTH_TURN  = 32'h2000_0000;
	localparam logic [PHASE_W-1:0] PHASE_BIAS   = OFFSET_PHASE - EIGHTH_TURN;

	localparam logic signed [VEC_W-1:0] CORDIC_INV_GAIN = 32'sd652032874;

	localparam logic [VEC_W-1:0] ATAN_TURNS [0:ATAN_LEN-1] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	localparam logic [CFG_IDX_W-1:0] REG_SCAN_POINTS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_START    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_END      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PIX_PER_M    = 2'd3;

	localparam logic [SP_W-1:0]  RST_SCAN_POINTS = 12'd360;
	localparam logic [DEG_W-1:0] RST_WIN_START   = 9'd240;
	localparam logic [DEG_W-1:0] RST_WIN_END     = 9'd330;
	localparam logic [PPM_W-1:0] RST_PIX_PER_M   = 8'd120;
	localparam logic [BLK_W-1:0] RST_BLOCKS      = 4'd1;

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	// long division cell payload: partial remainder, dividend bits turning into quotient
	typedef struct packed {
		logic [REM_W-1:0]    rem;
		logic [DIV_BITS-1:0] work;
		logic [RS_W-1:0]     rs;
	} div_data_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [VEC_W-1:0] z;
		logic [1:0]              quad;
		logic [RS_W-1:0]         rs;
	} cordic_data_t;

endpackage

@@ sv/lpc_div_cell.sv @@
// one restoring long division step of the phase divider chain
module lpc_div_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [lpc_pkg::SP_W-1:0] divisor,
	input  logic                    in_valid,
	input  lpc_pkg::div_data_t      in_data,
	output logic                    out_valid,
	output lpc_pkg::div_data_t      out_data
);

	logic [lpc_pkg::REM_W:0] trial;
	logic [lpc_pkg::REM_W:0] diff;
	logic                    take;
	lpc_pkg::div_data_t      nxt;
	logic                    valid_q;
	lpc_pkg::div_data_t      data_q;

	always_comb begin
		trial = {in_data.rem, in_data.work[lpc_pkg::DIV_BITS-1]};
		diff  = trial - {1'b0, divisor};
		take  = (trial >= {1'b0, divisor});
		nxt.rem  = take ? diff[lpc_pkg::REM_W-1:0] : trial[lpc_pkg::REM_W-1:0];
		nxt.work = {in_data.work[lpc_pkg::DIV_BITS-2:0], take};
		nxt.rs   = in_data.rs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= nxt;
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

@@ sv/lpc_cordic_cell.sv @@
// one rotation-mode cordic micro-rotation
module lpc_cordic_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [lpc_pkg::SHIFT_W-1:0] shift,
	input  logic [lpc_pkg::VEC_W-1:0]   atan_step,
	input  logic                        in_valid,
	input  lpc_pkg::cordic_data_t       in_data,
	output logic                        out_valid,
	output lpc_pkg::cordic_data_t       out_data
);

	logic signed [lpc_pkg::VEC_W-1:0] dx;
	logic signed [lpc_pkg::VEC_W-1:0] dy;
	lpc_pkg::cordic_data_t            nxt;
	logic                             valid_q;
	lpc_pkg::cordic_data_t            data_q;

	always_comb begin
		dx  = in_data.y >>> shift;
		dy  = in_data.x >>> shift;
		nxt = in_data;
		if (!in_data.z[lpc_pkg::VEC_W-1]) begin
			nxt.x = in_data.x - dx;
			nxt.y = in_data.y + dy;
			nxt.z = in_data.z - $signed(atan_step);
		end else begin
			nxt.x = in_data.x + dx;
			nxt.y = in_data.y - dy;
			nxt.z = in_data.z + $signed(atan_step);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= nxt;
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

@@ sv/lpc_pixel.sv @@
// scales one unit-vector term by range times scale, rounds and saturates to pixels
module lpc_pixel (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic signed [lpc_pkg::VEC_W-1:0]  term,
	input  logic [lpc_pkg::RS_W-1:0]          rs,
	output logic                              out_valid,
	output logic signed [lpc_pkg::PIX_W-1:0]  pixel
);

	localparam int RND_W = lpc_pkg::PROD_W - lpc_pkg::FRAC_SHIFT;
	localparam logic signed [lpc_pkg::PROD_W-1:0] ROUND_HALF =
		lpc_pkg::PROD_W'(1) << (lpc_pkg::FRAC_SHIFT - 1);
	localparam logic signed [lpc_pkg::PIX_W-1:0] PIX_MAX = {1'b0, {(lpc_pkg::PIX_W-1){1'b1}}};
	localparam logic signed [lpc_pkg::PIX_W-1:0] PIX_MIN = {1'b1, {(lpc_pkg::PIX_W-1){1'b0}}};

	logic                               valid_s1;
	logic signed [lpc_pkg::PROD_W-1:0]  prod_s1;
	logic signed [lpc_pkg::PROD_W-1:0]  rounded;
	logic        [RND_W-1:0]            whole;
	logic signed [lpc_pkg::PIX_W-1:0]   sat;
	logic                               valid_s2;
	logic signed [lpc_pkg::PIX_W-1:0]   pix_s2;

	always_comb begin
		rounded = prod_s1 + ROUND_HALF;
		whole   = rounded[lpc_pkg::PROD_W-1:lpc_pkg::FRAC_SHIFT];
		// top two bits disagree: out of the 18 bit range
		if (!whole[RND_W-1] && whole[RND_W-2]) begin
			sat = PIX_MAX;
		end else if (whole[RND_W-1] && !whole[RND_W-2]) begin
			sat = PIX_MIN;
		end else begin
			sat = whole[lpc_pkg::PIX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= lpc_pkg::PROD_W'(term) * $signed({1'b0, rs});
		pix_s2  <= sat;
	end

	assign out_valid = valid_s2;
	assign pixel     = pix_s2;

endmodule

@@ sv/lidar_polar_to_cartesian.sv @@
// lidar range sample to display pixel converter: window filter, phase divider, cordic, scaling
// a kept sample shows on done after the entry register, divider cells, seed register,
// cordic cells, fold-back register and pixel registers; dropped samples never show
// throughput: one sample per cycle, set by the fully pipelined divider and cordic cell chains
// the receiver cannot stall; busy stays low and done is a one-cycle strobe
// reset clears every valid bit and restores the register defaults (360, 240, 330, 120)
module lidar_polar_to_cartesian (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [lpc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lpc_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [lpc_pkg::INDEX_BITS-1:0]       sample_index,
	input  logic [lpc_pkg::RANGE_W-1:0]          range_q8_8,
	output logic                                 done,
	output logic signed [lpc_pkg::PIX_W-1:0]     x_pixel,
	output logic signed [lpc_pkg::PIX_W-1:0]     y_pixel
);

	localparam int DIV_BITS    = lpc_pkg::DIV_BITS;
	localparam int STAGES      = lpc_pkg::CORDIC_STAGES;
	localparam int RESULT_LAG  = DIV_BITS + STAGES + 5;
	localparam int SEED_LAG    = DIV_BITS + STAGES + 4;

	// configuration
	logic [lpc_pkg::SP_W-1:0]       scan_points_q;
	logic [lpc_pkg::DEG_W-1:0]      win_start_q;
	logic [lpc_pkg::DEG_W-1:0]      win_end_q;
	logic [lpc_pkg::PPM_W-1:0]      pix_per_m_q;
	logic [lpc_pkg::BLK_W-1:0]      blocks_q;
	logic [lpc_pkg::BLK_PROD_W-1:0] blk_prod;

	always_comb begin
		blk_prod = lpc_pkg::BLK_PROD_W'(cfg_data[lpc_pkg::SP_W-1:lpc_pkg::BLK_PRE_SHIFT]) *
			lpc_pkg::BLK_PROD_W'(lpc_pkg::BLK_RECIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_points_q <= lpc_pkg::RST_SCAN_POINTS;
			win_start_q   <= lpc_pkg::RST_WIN_START;
			win_end_q     <= lpc_pkg::RST_WIN_END;
			pix_per_m_q   <= lpc_pkg::RST_PIX_PER_M;
			blocks_q      <= lpc_pkg::RST_BLOCKS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lpc_pkg::REG_SCAN_POINTS: begin
					scan_points_q <= cfg_data[lpc_pkg::SP_W-1:0];
					blocks_q      <= blk_prod[lpc_pkg::BLK_RECIP_SHIFT +: lpc_pkg::BLK_W];
				end
				lpc_pkg::REG_WIN_START: win_start_q <= cfg_data[lpc_pkg::DEG_W-1:0];
				lpc_pkg::REG_WIN_END:   win_end_q   <= cfg_data[lpc_pkg::DEG_W-1:0];
				lpc_pkg::REG_PIX_PER_M: pix_per_m_q <= cfg_data[lpc_pkg::PPM_W-1:0];
			endcase
		end
	end

	// window filter at the input transfer
	logic                          take;
	logic [lpc_pkg::WIN_W-1:0]     win_lo;
	logic [lpc_pkg::WIN_W-1:0]     win_hi;
	logic                          keep;
	logic                          entry_valid_s1;
	lpc_pkg::div_data_t            entry_s1;

	assign busy = 1'b0;
	assign take = start && !busy;

	always_comb begin
		win_lo = lpc_pkg::WIN_W'(win_start_q) * lpc_pkg::WIN_W'(blocks_q);
		win_hi = lpc_pkg::WIN_W'(win_end_q) * lpc_pkg::WIN_W'(blocks_q);
		keep   = (blocks_q != '0) && (range_q8_8 != '0) &&
			(lpc_pkg::CMP_W'(sample_index) >= lpc_pkg::CMP_W'(win_lo)) &&
			(lpc_pkg::CMP_W'(sample_index) < lpc_pkg::CMP_W'(win_hi));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_s1 <= 1'b0;
		end else begin
			entry_valid_s1 <= take && keep;
		end
	end

	// dividend is index * 2^32 + scan_points/2, so the quotient rounds half up
	always_ff @(posedge clk) begin
		entry_s1.rem  <= '0;
		entry_s1.work <= {sample_index,
			{(lpc_pkg::PHASE_W - lpc_pkg::SP_W + 1){1'b0}},
			scan_points_q[lpc_pkg::SP_W-1:1]};
		entry_s1.rs   <= lpc_pkg::RS_W'(range_q8_8) * lpc_pkg::RS_W'(pix_per_m_q);
	end

	// phase divider chain
	logic               div_valid [0:DIV_BITS];
	lpc_pkg::div_data_t div_data  [0:DIV_BITS];

	assign div_valid[0] = entry_valid_s1;
	assign div_data[0]  = entry_s1;

	for (genvar g = 0; g < DIV_BITS; g++) begin : g_div
		lpc_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.divisor   (scan_points_q),
			.in_valid  (div_valid[g]),
			.in_data   (div_data[g]),
			.out_valid (div_valid[g+1]),
			.out_data  (div_data[g+1])
		);
	end

	// quadrant split and cordic seed; the quotient bits above a full turn drop off
	logic [lpc_pkg::PHASE_W-1:0] phase_biased;
	logic                        seed_valid_s2;
	lpc_pkg::cordic_data_t       seed_s2;

	assign phase_biased = div_data[DIV_BITS].work[lpc_pkg::PHASE_W-1:0] - lpc_pkg::PHASE_BIAS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_valid_s2 <= 1'b0;
		end else begin
			seed_valid_s2 <= div_valid[DIV_BITS];
		end
	end

	// residual in [-1/8, 1/8) turn is the low 30 bits minus an eighth turn
	always_ff @(posedge clk) begin
		seed_s2.x    <= lpc_pkg::CORDIC_INV_GAIN;
		seed_s2.y    <= '0;
		seed_s2.z    <= lpc_pkg::VEC_W'($signed({~phase_biased[lpc_pkg::PHASE_W-3],
			phase_biased[lpc_pkg::PHASE_W-4:0]}));
		seed_s2.quad <= phase_biased[lpc_pkg::PHASE_W-1:lpc_pkg::PHASE_W-2];
		seed_s2.rs   <= div_data[DIV_BITS].rs;
	end

	// cordic chain
	logic                  rot_valid [0:STAGES];
	lpc_pkg::cordic_data_t rot_data  [0:STAGES];

	assign rot_valid[0] = seed_valid_s2;
	assign rot_data[0]  = seed_s2;

	for (genvar g = 0; g < STAGES; g++) begin : g_rot
		lpc_cordic_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift     (lpc_pkg::SHIFT_W'(g)),
			.atan_step (lpc_pkg::ATAN_TURNS[g]),
			.in_valid  (rot_valid[g]),
			.in_data   (rot_data[g]),
			.out_valid (rot_valid[g+1]),
			.out_data  (rot_data[g+1])
		);
	end

	// quadrant fold-back; x takes the negated cosine term
	logic signed [lpc_pkg::VEC_W-1:0] term_x;
	logic signed [lpc_pkg::VEC_W-1:0] term_y;
	logic                             map_valid_s3;
	logic signed [lpc_pkg::VEC_W-1:0] term_x_s3;
	logic signed [lpc_pkg::VEC_W-1:0] term_y_s3;
	logic [lpc_pkg::RS_W-1:0]         rs_s3;

	always_comb begin
		unique case (rot_data[STAGES].quad)
			lpc_pkg::QUAD_0: begin
				term_x = -rot_data[STAGES].x;
				term_y = rot_data[STAGES].y;
			end
			lpc_pkg::QUAD_1: begin
				term_x = rot_data[STAGES].y;
				term_y = rot_data[STAGES].x;
			end
			lpc_pkg::QUAD_2: begin
				term_x = rot_data[STAGES].x;
				term_y = -rot_data[STAGES].y;
			end
			lpc_pkg::QUAD_3: begin
				term_x = -rot_data[STAGES].y;
				term_y = -rot_data[STAGES].x;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_valid_s3 <= 1'b0;
		end else begin
			map_valid_s3 <= rot_valid[STAGES];
		end
	end

	always_ff @(posedge clk) begin
		term_x_s3 <= term_x;
		term_y_s3 <= term_y;
		rs_s3     <= rot_data[STAGES].rs;
	end

	// scaling to pixels
	logic y_valid;

	lpc_pixel u_pix_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (map_valid_s3),
		.term      (term_x_s3),
		.rs        (rs_s3),
		.out_valid (done),
		.pixel     (x_pixel)
	);

	lpc_pixel u_pix_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (map_valid_s3),
		.term      (term_y_s3),
		.rs        (rs_s3),
		.out_valid (y_valid),
		.pixel     (y_pixel)
	);

	// both coordinate lanes deliver together
	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		done == y_valid)
		else $error("x and y pixel lanes out of step");

	// a sample with no return never leads to a result
	a_no_return_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(take && range_q8_8 == '0) |-> ##(RESULT_LAG) !done)
		else $error("result produced for a zero range sample");

	// every kept sample comes out after the fixed pipeline depth
	a_kept_delivered: assert property (@(posedge clk) disable iff (!arst_n)
		entry_valid_s1 |-> ##(SEED_LAG) done)
		else $error("kept sample lost in the pipeline");

endmodule
